// File: rtl/i2ctbe_pkg.sv
// ============================================================================
// i2ctbe_pkg
// Shared types and constants of the I2C target byte engine.
// ============================================================================
package i2ctbe_pkg;

    localparam int DEF_BUF_DEPTH = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [3:0] RELEASE_TICKS_RST = 4'd10;

    typedef enum logic [1:0] {
        KIND_SDA  = 2'd0,
        KIND_SCL  = 2'd1,
        KIND_TICK = 2'd2,
        KIND_LOAD = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_ADDRESS   = 2'd0,
        CFG_RX_SIZE       = 2'd1,
        CFG_TX_SIZE       = 2'd2,
        CFG_RELEASE_TICKS = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic       sda_drive_low;
        logic       rx_valid;
        logic [7:0] rx_index;
        logic [7:0] rx_data;
        logic       start_read;
        logic       start_write;
        logic       write_done;
        logic       read_done;
        logic       safety_released;
    } t_result;

endpackage

// File: rtl/i2c_target_byte_engine_unit.sv
// ============================================================================
// i2c_target_byte_engine_unit
// I2C target with 7-bit address: START/STOP detection, address match, write
// byte delivery with acknowledge, read bit driving and an SDA safety release.
// ============================================================================
// Output: a result word is presented in the cycle after its event is accepted.
// Throughput: one event per cycle while the result word is not stalled; the
// bus state is updated every cycle, the current byte only on advance or load.
// Reset: synchronous, active low; resets bus state and configuration. The
// transmit store is not cleared and holds garbage until loaded.
module i2c_target_byte_engine_unit
    import i2ctbe_pkg::*;
#(
    parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // event channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_kind,
    input  logic                  i_sda_level,
    input  logic                  i_scl_level,
    input  logic [7:0]            i_tx_index,
    input  logic [7:0]            i_tx_data,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_sda_drive_low,
    output logic                  o_rx_valid,
    output logic [7:0]            o_rx_index,
    output logic [7:0]            o_rx_data,
    output logic                  o_start_read,
    output logic                  o_start_write,
    output logic                  o_write_done,
    output logic                  o_read_done,
    output logic                  o_safety_released,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int TX_LIM = (BUF_DEPTH < 256) ? BUF_DEPTH : 256;

    // configuration
    logic [6:0] r_own_address;
    logic [8:0] r_rx_size;
    logic [8:0] r_tx_size;
    logic [3:0] r_release_ticks;

    // bus state
    logic signed [4:0] r_bit_count,  n_bit_count;
    logic signed [9:0] r_byte_count, n_byte_count;
    logic [7:0]        r_shift_byte, n_shift_byte;
    logic              r_master_reads, n_master_reads;
    logic              r_clock_listen, n_clock_listen;
    logic              r_drive_low, n_drive_low;
    logic [3:0]        r_release_count, n_release_count;

    // transmit store and prefetch of bytes byte_count and byte_count + 1
    logic [7:0] r_tx_mem [BUF_DEPTH];
    logic [7:0] r_cur_byte;
    logic [7:0] r_nxt_byte;

    logic    r_out_valid;
    t_result r_result, n_result;

    logic              accept;
    t_kind             kind;
    logic [8:0]        rx_eff;
    logic [8:0]        tx_eff;
    logic signed [10:0] rx_eff_s;
    logic signed [10:0] tx_eff_s;
    logic signed [10:0] byte_s;
    logic signed [10:0] nbyte_s;
    logic              byte_incr;
    logic              load_hit;
    logic [12:0]       wr_addr;
    logic signed [10:0] rd_sum;
    logic [12:0]       rd_addr;
    logic [7:0]        sel_byte;
    logic              pull;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign kind       = t_kind'(i_kind);

    assign rx_eff   = (r_rx_size > 9'd256) ? 9'd256 : r_rx_size;
    assign tx_eff   = (r_tx_size > 9'(TX_LIM)) ? 9'(TX_LIM) : r_tx_size;
    assign rx_eff_s = $signed({2'b00, rx_eff});
    assign tx_eff_s = $signed({2'b00, tx_eff});
    assign byte_s   = {r_byte_count[9], r_byte_count};

    assign wr_addr  = {5'd0, i_tx_index};
    assign load_hit = accept && (kind == KIND_LOAD) && (wr_addr < 13'(BUF_DEPTH));

    always_comb begin
        n_bit_count     = r_bit_count;
        n_byte_count    = r_byte_count;
        n_shift_byte    = r_shift_byte;
        n_master_reads  = r_master_reads;
        n_clock_listen  = r_clock_listen;
        n_drive_low     = r_drive_low;
        n_release_count = r_release_count;
        byte_incr       = 1'b0;
        nbyte_s         = byte_s;
        sel_byte        = r_cur_byte;
        pull            = 1'b0;
        n_result        = '0;

        if (accept) begin
            case (kind)
                KIND_SDA: begin
                    if (i_scl_level) begin
                        if (i_sda_level) begin
                            n_clock_listen = 1'b0;
                        end else begin
                            n_bit_count    = -5'sd1;
                            n_byte_count   = -10'sd1;
                            n_clock_listen = 1'b1;
                        end
                    end
                end
                KIND_SCL: begin
                    if (r_clock_listen && i_scl_level) begin
                        if (r_bit_count < 5'sd8) begin
                            n_shift_byte = {(r_bit_count == 5'sd0) ? 7'd0
                                                                   : r_shift_byte[6:0],
                                            i_sda_level};
                            if (r_bit_count == 5'sd7) begin
                                if (r_byte_count == -10'sd1) begin
                                    if (n_shift_byte[7:1] != r_own_address) begin
                                        n_clock_listen = 1'b0;
                                    end else begin
                                        n_master_reads = n_shift_byte[0];
                                    end
                                end else if (!r_master_reads && byte_s < rx_eff_s) begin
                                    n_result.rx_valid = 1'b1;
                                    n_result.rx_index = r_byte_count[7:0];
                                    n_result.rx_data  = n_shift_byte;
                                end
                            end
                        end
                    end else if (r_clock_listen) begin
                        if (r_bit_count == 5'sd8) begin
                            if (r_byte_count == -10'sd1) begin
                                n_result.start_read  = r_master_reads;
                                n_result.start_write = !r_master_reads;
                            end
                            n_result.write_done = !r_master_reads
                                                  && (byte_s == rx_eff_s - 11'sd1);
                            n_result.read_done  = r_master_reads
                                                  && (byte_s == tx_eff_s - 11'sd1);
                            // wrap after the acknowledge bit
                            n_bit_count = 5'sd0;
                            if (r_byte_count < 10'sd511) begin
                                n_byte_count = r_byte_count + 10'sd1;
                                byte_incr    = 1'b1;
                            end
                        end else begin
                            n_bit_count = r_bit_count + 5'sd1;
                        end
                        nbyte_s  = {n_byte_count[9], n_byte_count};
                        sel_byte = byte_incr ? r_nxt_byte : r_cur_byte;
                        if (n_bit_count == 5'sd8) begin
                            pull = (n_byte_count == -10'sd1)
                                   || (!r_master_reads && nbyte_s < rx_eff_s);
                        end else if (n_bit_count >= 5'sd0 && r_master_reads
                                     && nbyte_s >= 11'sd0 && nbyte_s < tx_eff_s) begin
                            // send MSB first
                            pull = !sel_byte[~n_bit_count[2:0]];
                        end
                        n_release_count = pull ? r_release_ticks : 4'd0;
                        n_drive_low     = pull;
                    end
                end
                KIND_TICK: begin
                    if (r_release_count != 4'd0) begin
                        n_release_count = r_release_count - 4'd1;
                        if (r_release_count == 4'd1) begin
                            n_drive_low              = 1'b0;
                            n_result.safety_released = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        n_result.sda_drive_low = n_drive_low;
    end

    assign rd_sum  = {n_byte_count[9], n_byte_count} + 11'sd1;
    assign rd_addr = {2'b00, rd_sum};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address   <= '0;
            r_rx_size       <= '0;
            r_tx_size       <= '0;
            r_release_ticks <= RELEASE_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_OWN_ADDRESS:   r_own_address   <= i_cfg_data[6:0];
                CFG_RX_SIZE:       r_rx_size       <= i_cfg_data[8:0];
                CFG_TX_SIZE:       r_tx_size       <= i_cfg_data[8:0];
                CFG_RELEASE_TICKS: r_release_ticks <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count     <= '0;
            r_byte_count    <= '0;
            r_shift_byte    <= '0;
            r_master_reads  <= 1'b0;
            r_clock_listen  <= 1'b1;
            r_drive_low     <= 1'b0;
            r_release_count <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_bit_count     <= n_bit_count;
            r_byte_count    <= n_byte_count;
            r_shift_byte    <= n_shift_byte;
            r_master_reads  <= n_master_reads;
            r_clock_listen  <= n_clock_listen;
            r_drive_low     <= n_drive_low;
            r_release_count <= n_release_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    // transmit store with registered read of byte_count + 1, write bypassed
    always_ff @(posedge i_clk) begin
        if (load_hit) begin
            r_tx_mem[wr_addr[AW-1:0]] <= i_tx_data;
        end
        if (load_hit && wr_addr == rd_addr) begin
            r_nxt_byte <= i_tx_data;
        end else if (rd_addr < 13'(BUF_DEPTH)) begin
            r_nxt_byte <= r_tx_mem[rd_addr[AW-1:0]];
        end
        if (byte_incr) begin
            r_cur_byte <= r_nxt_byte;
        end else if (load_hit && {2'b00, i_tx_index} == r_byte_count) begin
            r_cur_byte <= i_tx_data;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_sda_drive_low   = r_result.sda_drive_low;
    assign o_rx_valid        = r_result.rx_valid;
    assign o_rx_index        = r_result.rx_index;
    assign o_rx_data         = r_result.rx_data;
    assign o_start_read      = r_result.start_read;
    assign o_start_write     = r_result.start_write;
    assign o_write_done      = r_result.write_done;
    assign o_read_done       = r_result.read_done;
    assign o_safety_released = r_result.safety_released;

endmodule

// File: rtl/i2ctbe_checker.sv
// ============================================================================
// i2ctbe_checker
// Port-level checks of the I2C target byte engine, bound to the top level.
// ============================================================================
module i2ctbe_checker
    import i2ctbe_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_sda_drive_low,
    input logic       o_rx_valid,
    input logic       o_start_read,
    input logic       o_start_write,
    input logic       o_safety_released
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result word dropped while stalled");

    // a released line is never reported as driven low
    a_release_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_safety_released) |-> !o_sda_drive_low)
        else $error("safety release with SDA still driven");

    // byte delivery comes with SCL high, the address acknowledge with SCL low
    a_rx_vs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rx_valid) |-> (!o_start_read && !o_start_write))
        else $error("byte delivered on an acknowledge edge");

    a_start_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_start_read && o_start_write))
        else $error("read and write start together");

    // write transfer: after the address acknowledge the target releases SDA
    a_write_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_start_write) |-> !o_sda_drive_low)
        else $error("SDA held after write address acknowledge");

endmodule

bind i2c_target_byte_engine_unit i2ctbe_checker u_i2ctbe_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_sda_drive_low   (o_sda_drive_low),
    .o_rx_valid        (o_rx_valid),
    .o_start_read      (o_start_read),
    .o_start_write     (o_start_write),
    .o_safety_released (o_safety_released)
);

// File: tb/target_event_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// target_event_checker
// Watches the event and result channels of the I2C target byte engine, keeps
// its own model of the bus state, register copies and transmit store, and
// compares every result word field by field with the oldest prediction.
// ============================================================================
module target_event_checker
    import i2ctbe_pkg::*;
#(
    parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [1:0]            i_kind,
    input  logic                  i_sda_level,
    input  logic                  i_scl_level,
    input  logic [7:0]            i_tx_index,
    input  logic [7:0]            i_tx_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_sda_drive_low,
    input  logic                  i_rx_valid,
    input  logic [7:0]            i_rx_index,
    input  logic [7:0]            i_rx_data,
    input  logic                  i_start_read,
    input  logic                  i_start_write,
    input  logic                  i_write_done,
    input  logic                  i_read_done,
    input  logic                  i_safety_released,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_outstanding,
    output int                    o_errors
);

    localparam int TX_CAP = (BUF_DEPTH < 256) ? BUF_DEPTH : 256;

    // register copies
    logic [6:0] own_addr;
    logic [8:0] rx_size;
    logic [8:0] tx_size;
    logic [3:0] release_ticks;

    // bus state
    int         bit_cnt;
    int         byte_cnt;
    logic [7:0] shift_reg;
    logic       reading;
    logic       listening;
    logic       drive_low;
    logic [3:0] release_cnt;
    logic [7:0] tx_mem [BUF_DEPTH];

    t_result predicted_results [$];
    t_result want;
    int      mismatches = 0;

    assign o_errors = mismatches;

    initial o_outstanding = 0;

    function automatic t_result step_target(t_kind k, logic sda, logic scl,
                                            logic [7:0] idx, logic [7:0] dat);
        t_result r;
        logic    pull;
        int      rx_lim;
        int      tx_lim;
        r = '0;
        rx_lim = (rx_size > 9'd256) ? 256 : int'(rx_size);
        tx_lim = (int'(tx_size) > TX_CAP) ? TX_CAP : int'(tx_size);
        case (k)
            KIND_SDA: begin
                // SDA moving while SCL is high: rising is STOP, falling is START
                if (scl) begin
                    if (sda) begin
                        listening = 1'b0;
                    end else begin
                        bit_cnt   = -1;
                        byte_cnt  = -1;
                        listening = 1'b1;
                    end
                end
            end
            KIND_SCL: begin
                if (listening) begin
                    if (scl) begin
                        if (bit_cnt < 8) begin
                            if (bit_cnt == 0) shift_reg = '0;
                            shift_reg = {shift_reg[6:0], sda};
                            if (bit_cnt == 7) begin
                                if (byte_cnt == -1) begin
                                    if (shift_reg[7:1] != own_addr) listening = 1'b0;
                                    else reading = shift_reg[0];
                                end else if (!reading && byte_cnt < rx_lim) begin
                                    r.rx_valid = 1'b1;
                                    r.rx_index = byte_cnt[7:0];
                                    r.rx_data  = shift_reg;
                                end
                            end
                        end
                    end else begin
                        if (bit_cnt == 8) begin
                            if (byte_cnt == -1) begin
                                if (reading) r.start_read = 1'b1;
                                else r.start_write = 1'b1;
                            end
                            if (!reading && byte_cnt == rx_lim - 1) r.write_done = 1'b1;
                            if (reading && byte_cnt == tx_lim - 1) r.read_done = 1'b1;
                        end
                        bit_cnt++;
                        if (bit_cnt == 9) begin
                            bit_cnt = 0;
                            if (byte_cnt < 511) byte_cnt++;
                        end
                        // acknowledge slot first, then the transmit bit, MSB first
                        pull = (bit_cnt == 8 &&
                                (byte_cnt == -1 || (!reading && byte_cnt < rx_lim)));
                        if (!pull && bit_cnt >= 0 && bit_cnt < 8 && reading &&
                            byte_cnt >= 0 && byte_cnt < tx_lim)
                            pull = !tx_mem[byte_cnt][7 - bit_cnt];
                        release_cnt = pull ? release_ticks : 4'd0;
                        drive_low   = pull;
                    end
                end
            end
            KIND_TICK: begin
                if (release_cnt != 4'd0) begin
                    release_cnt--;
                    if (release_cnt == 4'd0) begin
                        drive_low         = 1'b0;
                        r.safety_released = 1'b1;
                    end
                end
            end
            KIND_LOAD: begin
                if (int'(idx) < BUF_DEPTH) tx_mem[idx] = dat;
            end
            default: ;
        endcase
        r.sda_drive_low = drive_low;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_val,
                                        logic [7:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            own_addr      = '0;
            rx_size       = '0;
            tx_size       = '0;
            release_ticks = RELEASE_TICKS_RST;
            bit_cnt       = 0;
            byte_cnt      = 0;
            shift_reg     = '0;
            reading       = 1'b0;
            listening     = 1'b1;
            drive_low     = 1'b0;
            release_cnt   = '0;
            predicted_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_OWN_ADDRESS:   own_addr      = i_cfg_data[6:0];
                    CFG_RX_SIZE:       rx_size       = i_cfg_data[8:0];
                    CFG_TX_SIZE:       tx_size       = i_cfg_data[8:0];
                    CFG_RELEASE_TICKS: release_ticks = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            // compare before predicting: a word out is never for the word just in
            if (i_out_valid && i_out_ready) begin
                if (predicted_results.size() == 0) begin
                    $error("result word with no prediction pending");
                    mismatches++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("sda_drive_low", want.sda_drive_low, i_sda_drive_low);
                    check_field("rx_valid", want.rx_valid, i_rx_valid);
                    check_field("rx_index", want.rx_index, i_rx_index);
                    check_field("rx_data", want.rx_data, i_rx_data);
                    check_field("start_read", want.start_read, i_start_read);
                    check_field("start_write", want.start_write, i_start_write);
                    check_field("write_done", want.write_done, i_write_done);
                    check_field("read_done", want.read_done, i_read_done);
                    check_field("safety_released", want.safety_released,
                                i_safety_released);
                end
            end
            if (i_in_valid && i_in_ready)
                predicted_results.push_back(step_target(t_kind'(i_kind), i_sda_level,
                                                        i_scl_level, i_tx_index,
                                                        i_tx_data));
        end
        o_outstanding <= predicted_results.size();
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Testbench top for the I2C target byte engine: drives bus pin events, safety
// ticks and transmit loads as well-formed transfers mixed with noise, under
// several register settings and idle patterns; the checker does the scoring.
// ============================================================================
module tb;
    import i2ctbe_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int ROUND_WORDS = 30;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic [1:0]            ev_kind   = KIND_TICK;
    logic                  ev_sda    = 1'b1;
    logic                  ev_scl    = 1'b1;
    logic [7:0]            ev_idx    = '0;
    logic [7:0]            ev_dat    = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_OWN_ADDRESS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic       in_ready;
    logic       out_valid;
    logic       sda_drive_low;
    logic       rx_valid;
    logic [7:0] rx_index;
    logic [7:0] rx_data;
    logic       start_read;
    logic       start_write;
    logic       write_done;
    logic       read_done;
    logic       safety_released;

    int outstanding;
    int errors;

    int send_idle_pct = 29;
    int recv_idle_pct = 59;
    int tick_pct      = 0;
    int words_sent    = 0;
    int stall_cycles  = 0;

    // bus levels as last sent, and what the stimulus knows of the target
    logic       bus_sda = 1'b1;
    logic       bus_scl = 1'b1;
    logic [6:0] cfg_own = '0;
    bit         loaded [DEF_BUF_DEPTH];

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    i2c_target_byte_engine_unit dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_kind            (ev_kind),
        .i_sda_level       (ev_sda),
        .i_scl_level       (ev_scl),
        .i_tx_index        (ev_idx),
        .i_tx_data         (ev_dat),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_sda_drive_low   (sda_drive_low),
        .o_rx_valid        (rx_valid),
        .o_rx_index        (rx_index),
        .o_rx_data         (rx_data),
        .o_start_read      (start_read),
        .o_start_write     (start_write),
        .o_write_done      (write_done),
        .o_read_done       (read_done),
        .o_safety_released (safety_released),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    target_event_checker checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_kind            (ev_kind),
        .i_sda_level       (ev_sda),
        .i_scl_level       (ev_scl),
        .i_tx_index        (ev_idx),
        .i_tx_data         (ev_dat),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_sda_drive_low   (sda_drive_low),
        .i_rx_valid        (rx_valid),
        .i_rx_index        (rx_index),
        .i_rx_data         (rx_data),
        .i_start_read      (start_read),
        .i_start_write     (start_write),
        .i_write_done      (write_done),
        .i_read_done       (read_done),
        .i_safety_released (safety_released),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_outstanding     (outstanding),
        .o_errors          (errors)
    );

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_word(input t_kind k, input logic sda, input logic scl,
                             input logic [7:0] idx, input logic [7:0] dat);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ev_kind  <= k;
        ev_sda   <= sda;
        ev_scl   <= scl;
        ev_idx   <= idx;
        ev_dat   <= dat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic maybe_ticks();
        int n;
        if ($urandom_range(99) < tick_pct) begin
            // long bursts reach the largest release count
            n = ($urandom_range(99) < 20) ? $urandom_range(4, 17) : 1;
            repeat (n) send_word(KIND_TICK, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic set_sda(input logic lvl);
        maybe_ticks();
        bus_sda = lvl;
        send_word(KIND_SDA, lvl, bus_scl, $urandom, $urandom);
    endtask

    task automatic set_scl(input logic lvl);
        maybe_ticks();
        bus_scl = lvl;
        send_word(KIND_SCL, bus_sda, lvl, $urandom, $urandom);
    endtask

    task automatic load_byte(input logic [7:0] idx, input logic [7:0] dat);
        loaded[idx] = 1'b1;
        send_word(KIND_LOAD, $urandom, $urandom, idx, dat);
    endtask

    task automatic bus_start();
        if (!bus_sda) begin
            if (bus_scl) set_scl(1'b0);
            set_sda(1'b1);
        end
        if (!bus_scl) set_scl(1'b1);
        set_sda(1'b0);
        set_scl(1'b0);
    endtask

    task automatic bus_stop();
        if (!(bus_scl && !bus_sda)) begin
            if (bus_scl) set_scl(1'b0);
            if (bus_sda) set_sda(1'b0);
            set_scl(1'b1);
        end
        set_sda(1'b1);
    endtask

    task automatic clock_bit(input logic b);
        if (b != bus_sda) set_sda(b);
        set_scl(1'b1);
        set_scl(1'b0);
    endtask

    // eight data bits and the acknowledge clock
    task automatic put_byte(input logic [7:0] v, input logic ack_lvl);
        for (int i = 7; i >= 0; i--) clock_bit(v[i]);
        clock_bit(ack_lvl);
    endtask

    task automatic noise_burst();
        t_kind      k;
        logic       sda;
        logic       scl;
        logic [7:0] idx;
        repeat ($urandom_range(1, 6)) begin
            k   = t_kind'($urandom_range(0, 3));
            sda = $urandom;
            scl = $urandom;
            idx = $urandom;
            if (k == KIND_SDA || k == KIND_SCL) begin
                bus_sda = sda;
                bus_scl = scl;
            end
            if (k == KIND_LOAD) loaded[idx] = 1'b1;
            send_word(k, sda, scl, idx, $urandom);
        end
    endtask

    task automatic bus_transfer(input logic [6:0] addr, input logic rw,
                                input int nbytes, input bit noisy);
        bus_start();
        put_byte({addr, rw}, $urandom);
        for (int i = 0; i < nbytes; i++) begin
            if (noisy && $urandom_range(99) < 2) noise_burst();
            put_byte($urandom, $urandom);
        end
        // otherwise leave the bus for a repeated start
        if ($urandom_range(99) < 75) bus_stop();
    endtask

    // every entry a read may reach is written before the size allows it
    task automatic fill_store(input int n);
        for (int i = 0; i < n; i++)
            if (!loaded[i]) load_byte(i, $urandom);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic configure(input logic [6:0] own, input logic [8:0] rx,
                             input logic [8:0] tx, input logic [3:0] rel);
        cfg_own = own;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_OWN_ADDRESS;
        cfg_data  <= {2'b00, own};
        @(posedge clk);
        cfg_index <= CFG_RX_SIZE;
        cfg_data  <= rx;
        @(posedge clk);
        cfg_index <= CFG_TX_SIZE;
        cfg_data  <= tx;
        @(posedge clk);
        cfg_index <= CFG_RELEASE_TICKS;
        cfg_data  <= {5'd0, rel};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int         round_end;
        int         pick;
        logic [6:0] own;
        logic [6:0] addr;
        logic [8:0] rx;
        logic [8:0] tx;
        logic [3:0] rel;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: address zero, zero sizes flag done at the address ack
        bus_start();
        put_byte(8'h00, 1'b0);
        bus_stop();
        load_byte(8'hFF, 8'hFF);
        load_byte(8'h00, 8'h00);
        send_word(KIND_TICK, 1'b0, 1'b0, 8'h00, 8'h00);

        tick_pct = 12;
        for (int r = 0; r < 7; r++) begin
            case (r)
                0: begin
                    own = $urandom_range(1, 126);
                    rx  = $urandom_range(1, 8);
                    tx  = $urandom_range(1, 8);
                    rel = $urandom_range(1, 14);
                end
                1: begin
                    own = 7'd0;
                    rx  = 9'd0;
                    tx  = 9'd0;
                    rel = 4'd0;
                end
                2: begin
                    own = 7'd127;
                    rx  = 9'd1;
                    tx  = 9'd1;
                    rel = 4'd15;
                end
                3: begin
                    own = $urandom;
                    rx  = $urandom_range(0, 12);
                    tx  = $urandom_range(0, 12);
                    rel = $urandom;
                end
                4: begin
                    own = $urandom;
                    rx  = $urandom_range(2, 6);
                    tx  = $urandom_range(2, 6);
                    rel = $urandom_range(1, 3);
                end
                5: begin
                    own = $urandom;
                    rx  = 9'd256;
                    tx  = 9'd511;
                    rel = $urandom;
                end
                default: begin
                    own = $urandom;
                    rx  = $urandom_range(257, 511);
                    tx  = 9'd256;
                    rel = $urandom;
                end
            endcase
            fill_store((tx > 9'd256) ? 256 : int'(tx));
            settle();
            configure(own, rx, tx, rel);

            if (r < 2) begin
                send_idle_pct = 29;
                recv_idle_pct = 59;
            end else if (r < 4) begin
                send_idle_pct = 59;
                recv_idle_pct = 29;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            round_end = words_sent + ROUND_WORDS;
            while (words_sent < round_end) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    if ($urandom_range(99) < 85) addr = cfg_own;
                    else addr = $urandom;
                    bus_transfer(addr, $urandom, $urandom_range(0, 4), 1'b1);
                end else if (pick < 85) begin
                    noise_burst();
                end else if (pick < 92) begin
                    load_byte($urandom, $urandom);
                end else if (pick < 95) begin
                    // hold off until the result channel is drained
                    settle();
                end else begin
                    repeat ($urandom_range(1, 16))
                        send_word(KIND_TICK, $urandom, $urandom, $urandom, $urandom);
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: i2c_target_byte_engine_unit.f
rtl/i2ctbe_pkg.sv
rtl/i2c_target_byte_engine_unit.sv
rtl/i2ctbe_checker.sv
tb/target_event_checker.sv
tb/tb.sv
